// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CHK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_CHK(name, clk, rst_n, prop, msg)
`endif

`ifndef SYNTH
`define ASSERT_NR(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_NR(name, clk, prop, msg)
`endif

`endif

// ===== rtl/rmj_pkg.sv =====
// ----------------------------------------------------------------------------
// rmj_pkg
// Types and constants shared by the radar measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmj_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int N_TERMS    = 6;
	localparam int LIMB_W     = 32;
	localparam int MUL_W      = 4 * DATA_WIDTH;
	localparam int MUL_LIMBS  = (MUL_W + LIMB_W - 1) / LIMB_W;
	localparam int MUL_LAT    = 3;
	localparam int SQ_W       = 2 * DATA_WIDTH;
	localparam int M_W        = 3 * DATA_WIDTH;
	localparam int DEN_W      = 6 * DATA_WIDTH;
	localparam int QUOT_W     = 8 * DATA_WIDTH + 2 * FRAC_BITS;
	localparam int PIPE_DEPTH = 3 * MUL_LAT + DATA_WIDTH + 3;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] pos_x;
		logic signed [DATA_WIDTH-1:0] pos_y;
		logic signed [DATA_WIDTH-1:0] vel_x;
		logic signed [DATA_WIDTH-1:0] vel_y;
	} vec_req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] range_dx;
		logic signed [DATA_WIDTH-1:0] range_dy;
		logic signed [DATA_WIDTH-1:0] bearing_dx;
		logic signed [DATA_WIDTH-1:0] bearing_dy;
		logic signed [DATA_WIDTH-1:0] rate_dx;
		logic signed [DATA_WIDTH-1:0] rate_dy;
		logic                         zero_position;
		logic                         saturated;
	} jac_req_t;

	typedef struct packed {
		logic               zero;
		logic [N_TERMS-1:0] neg;
	} info_t;

endpackage

// ===== rtl/radar_measurement_jacobian.sv =====
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Jacobian of the radar range, bearing and range-rate measurement with
// respect to a Q16.16 state vector.
// ----------------------------------------------------------------------------
// The block takes one state request per cycle when it is not stalled and
// returns its Jacobian terms exactly, truncated toward zero and saturated.
// Its pipeline is built from three chained three-stage
// wide multipliers (squares, then the cubed range and squared numerators)
// followed by the 32-stage bitwise quotient units, one result bit per stage.
// The pipeline moves as a whole: while a finished result is not taken, no
// new request enters.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radar_measurement_jacobian (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vec_valid,
	output logic              vec_ready,
	input  rmj_pkg::vec_req_t vec,
	output logic              jac_valid,
	input  logic              jac_ready,
	output rmj_pkg::jac_req_t jac
);

	localparam int DW   = rmj_pkg::DATA_WIDTH;
	localparam int FB   = rmj_pkg::FRAC_BITS;
	localparam int NT   = rmj_pkg::N_TERMS;
	localparam int LAT  = rmj_pkg::MUL_LAT;
	localparam int MW   = rmj_pkg::MUL_W;
	localparam int SW   = rmj_pkg::SQ_W;
	localparam int XW   = rmj_pkg::M_W;
	localparam int NW   = rmj_pkg::DEN_W;
	localparam int QW   = rmj_pkg::QUOT_W;
	localparam int PD   = rmj_pkg::PIPE_DEPTH;
	localparam logic [DW-1:0] HALF = DW'(1) << (DW - 1);
	localparam logic signed [DW-1:0] UNIT = DW'(64'd1 << FB);
	localparam logic [NT-1:0] SQ_SEL = 6'b110011;

	typedef struct packed {
		logic [DW-1:0] pm;
		logic [DW-1:0] qm;
		logic          pn;
		logic          qn;
		logic          vxn;
		logic          vyn;
		logic          zero;
	} side_a_t;

	typedef struct packed {
		logic [SW-1:0]  s;
		logic [SW-1:0]  pp;
		logic [SW-1:0]  qq;
		logic [DW-1:0]  pm;
		logic [DW-1:0]  qm;
		rmj_pkg::info_t info;
	} side_b_t;

	function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] raw);
		return raw[DW-1] ? (~raw + DW'(1)) : raw;
	endfunction

	logic          adv;
	logic [PD-1:0] valid_q;

	assign adv       = !jac_valid || jac_ready;
	assign vec_ready = adv;
	assign jac_valid = valid_q[PD-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[PD-2:0], vec_valid};
		end
	end

	side_a_t       side_s1;
	logic [DW-1:0] vxm_s1;
	logic [DW-1:0] vym_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.pm   <= magnitude(vec.pos_x);
			side_s1.qm   <= magnitude(vec.pos_y);
			side_s1.pn   <= vec.pos_x[DW-1];
			side_s1.qn   <= vec.pos_y[DW-1];
			side_s1.vxn  <= vec.vel_x[DW-1];
			side_s1.vyn  <= vec.vel_y[DW-1];
			side_s1.zero <= (vec.pos_x == '0) && (vec.pos_y == '0);
			vxm_s1       <= magnitude(vec.vel_x);
			vym_s1       <= magnitude(vec.vel_y);
		end
	end

	logic [2*MW-1:0] prod_pp, prod_qq, prod_ta, prod_tb;
	side_a_t         side_a_d [LAT];

	rmj_mul u_mul_pp (.clk(clk), .en(adv), .a(MW'(side_s1.pm)), .b(MW'(side_s1.pm)), .p(prod_pp));
	rmj_mul u_mul_qq (.clk(clk), .en(adv), .a(MW'(side_s1.qm)), .b(MW'(side_s1.qm)), .p(prod_qq));
	rmj_mul u_mul_ta (.clk(clk), .en(adv), .a(MW'(vxm_s1)), .b(MW'(side_s1.qm)), .p(prod_ta));
	rmj_mul u_mul_tb (.clk(clk), .en(adv), .a(MW'(vym_s1)), .b(MW'(side_s1.pm)), .p(prod_tb));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_a_d[0] <= side_s1;
			for (int n = 1; n < LAT; n++) begin
				side_a_d[n] <= side_a_d[n-1];
			end
		end
	end

	side_a_t        sa;
	logic [SW-1:0]  ta_w, tb_w, c_w;
	logic           an_w, bn_w, cn_w;
	rmj_pkg::info_t info_w;
	side_b_t        side_s2;
	logic [SW-1:0]  c_s2;

	assign sa   = side_a_d[LAT-1];
	assign ta_w = prod_ta[SW-1:0];
	assign tb_w = prod_tb[SW-1:0];

	always_comb begin
		an_w = sa.vxn ^ sa.qn;
		bn_w = sa.vyn ^ sa.pn;
		if (an_w != bn_w) begin
			c_w  = ta_w + tb_w;
			cn_w = an_w;
		end else if (ta_w >= tb_w) begin
			c_w  = ta_w - tb_w;
			cn_w = an_w;
		end else begin
			c_w  = tb_w - ta_w;
			cn_w = !an_w;
		end
		info_w.zero = sa.zero;
		info_w.neg  = {!(sa.pn ^ cn_w), sa.qn ^ cn_w, sa.pn, !sa.qn, sa.qn, sa.pn};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.s    <= prod_pp[SW-1:0] + prod_qq[SW-1:0];
			side_s2.pp   <= prod_pp[SW-1:0];
			side_s2.qq   <= prod_qq[SW-1:0];
			side_s2.pm   <= sa.pm;
			side_s2.qm   <= sa.qm;
			side_s2.info <= info_w;
			c_s2         <= c_w;
		end
	end

	logic [2*MW-1:0] prod_s2, prod_mq, prod_mp;
	side_b_t         side_b_d [LAT];

	rmj_mul u_mul_s2 (.clk(clk), .en(adv), .a(MW'(side_s2.s)), .b(MW'(side_s2.s)), .p(prod_s2));
	rmj_mul u_mul_mq (.clk(clk), .en(adv), .a(MW'(side_s2.qm)), .b(MW'(c_s2)), .p(prod_mq));
	rmj_mul u_mul_mp (.clk(clk), .en(adv), .a(MW'(side_s2.pm)), .b(MW'(c_s2)), .p(prod_mp));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_b_d[0] <= side_s2;
			for (int n = 1; n < LAT; n++) begin
				side_b_d[n] <= side_b_d[n-1];
			end
		end
	end

	logic [2*MW-1:0] prod_s3, prod_mq2, prod_mp2;
	side_b_t         side_c_d [LAT];

	rmj_mul u_mul_s3 (
		.clk(clk), .en(adv), .a(prod_s2[MW-1:0]), .b(MW'(side_b_d[LAT-1].s)), .p(prod_s3)
	);
	rmj_mul u_mul_mq2 (
		.clk(clk), .en(adv), .a(MW'(prod_mq[XW-1:0])), .b(MW'(prod_mq[XW-1:0])), .p(prod_mq2)
	);
	rmj_mul u_mul_mp2 (
		.clk(clk), .en(adv), .a(MW'(prod_mp[XW-1:0])), .b(MW'(prod_mp[XW-1:0])), .p(prod_mp2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_c_d[0] <= side_b_d[LAT-1];
			for (int n = 1; n < LAT; n++) begin
				side_c_d[n] <= side_c_d[n-1];
			end
		end
	end

	side_b_t        sc;
	logic [QW-1:0]  num_w [NT];
	logic [NW-1:0]  den_w [NT];
	logic [DW-1:0]  quo   [NT];
	rmj_pkg::info_t info_d [DW];

	assign sc = side_c_d[LAT-1];

	always_comb begin
		num_w[0] = QW'(sc.pp) << (2 * FB);
		num_w[1] = QW'(sc.qq) << (2 * FB);
		num_w[2] = QW'(sc.qm) << (2 * FB);
		num_w[3] = QW'(sc.pm) << (2 * FB);
		num_w[4] = QW'(prod_mq2[2*XW-1:0]) << (2 * FB);
		num_w[5] = QW'(prod_mp2[2*XW-1:0]) << (2 * FB);
		for (int t = 0; t < 4; t++) begin
			den_w[t] = NW'(sc.s);
		end
		den_w[4] = prod_s3[NW-1:0];
		den_w[5] = prod_s3[NW-1:0];
	end

	for (genvar t = 0; t < NT; t++) begin : g_term
		rmj_quot u_quot (
			.clk (clk),
			.en  (adv),
			.num (num_w[t]),
			.den (den_w[t]),
			.sq  (SQ_SEL[t]),
			.k   (quo[t])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_d[0] <= sc.info;
			for (int n = 1; n < DW; n++) begin
				info_d[n] <= info_d[n-1];
			end
		end
	end

	rmj_pkg::info_t    fi;
	logic [DW-1:0]     cap_w [NT];
	logic [DW-1:0]     mag_w [NT];
	logic [DW-1:0]     val_w [NT];
	logic [NT-1:0]     over_w;
	rmj_pkg::jac_req_t res_w;
	rmj_pkg::jac_req_t res_s6;

	assign fi = info_d[DW-1];

	always_comb begin
		for (int t = 0; t < NT; t++) begin
			cap_w[t]  = fi.neg[t] ? HALF : HALF - DW'(1);
			over_w[t] = quo[t] > cap_w[t];
			mag_w[t]  = over_w[t] ? cap_w[t] : quo[t];
			val_w[t]  = fi.neg[t] ? (~mag_w[t] + DW'(1)) : mag_w[t];
			if (fi.zero) begin
				val_w[t] = '0;
			end
		end
		res_w.range_dx      = val_w[0];
		res_w.range_dy      = val_w[1];
		res_w.bearing_dx    = val_w[2];
		res_w.bearing_dy    = val_w[3];
		res_w.rate_dx       = val_w[4];
		res_w.rate_dy       = val_w[5];
		res_w.zero_position = fi.zero;
		res_w.saturated     = !fi.zero && (|over_w);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6 <= res_w;
		end
	end

	assign jac = res_s6;

	`ASSERT_CHK(a_zero_clears, clk, arst_n, jac_valid && jac.zero_position |-> jac.range_dx == '0 && jac.range_dy == '0 && jac.bearing_dx == '0 && jac.bearing_dy == '0 && jac.rate_dx == '0 && jac.rate_dy == '0 && !jac.saturated, "Zero position result is not cleared.")
	`ASSERT_CHK(a_unit_range, clk, arst_n, jac_valid && !jac.zero_position |-> jac.range_dx <= UNIT && jac.range_dx >= -UNIT && jac.range_dy <= UNIT && jac.range_dy >= -UNIT, "Range derivative exceeds one.")
	`ASSERT_CHK(a_bearing_x_sign, clk, arst_n, jac_valid && !jac.zero_position && jac.range_dy > 0 |-> jac.bearing_dx <= 0, "Bearing x term has the wrong sign.")
	`ASSERT_CHK(a_bearing_y_sign, clk, arst_n, jac_valid && !jac.zero_position && jac.range_dx > 0 |-> jac.bearing_dy >= 0, "Bearing y term has the wrong sign.")
	`ASSERT_CHK(a_stall_freeze, clk, arst_n, !vec_ready |=> $stable(valid_q), "Pipeline moved during a stall.")

endmodule

// ===== rtl/rmj_mul.sv =====
// ----------------------------------------------------------------------------
// rmj_mul
// Wide unsigned multiplier: limb products, row sums and final sum in three
// register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmj_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rmj_pkg::MUL_W-1:0]     a,
	input  logic [rmj_pkg::MUL_W-1:0]     b,
	output logic [2*rmj_pkg::MUL_W-1:0]   p
);

	localparam int LW = rmj_pkg::LIMB_W;
	localparam int NL = rmj_pkg::MUL_LIMBS;
	localparam int PW = NL * LW;
	localparam int RW = (NL + 1) * LW;

	logic [PW-1:0]   a_pad;
	logic [PW-1:0]   b_pad;
	logic [2*LW-1:0] pp_s1  [NL][NL];
	logic [RW-1:0]   row_w  [NL];
	logic [RW-1:0]   row_s2 [NL];
	logic [2*PW-1:0] sum_w;

	assign a_pad = PW'(a);
	assign b_pad = PW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++) begin
				for (int j = 0; j < NL; j++) begin
					pp_s1[i][j] <= (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			row_w[i] = '0;
			for (int j = 0; j < NL; j++) begin
				row_w[i] = row_w[i] + (RW'(pp_s1[i][j]) << (j * LW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_w;
		end
	end

	always_comb begin
		sum_w = '0;
		for (int i = 0; i < NL; i++) begin
			sum_w = sum_w + ((2*PW)'(row_s2[i]) << (i * LW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sum_w[2*rmj_pkg::MUL_W-1:0];
		end
	end

endmodule

// ===== rtl/rmj_quot.sv =====
// ----------------------------------------------------------------------------
// rmj_quot
// Pipelined restoring quotient, one result bit per stage. With sq low it finds
// the largest k with k*den <= num; with sq high, the largest k with
// k*k*den <= num, keeping k*den alongside the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmj_quot (
	input  logic                              clk,
	input  logic                              en,
	input  logic [rmj_pkg::QUOT_W-1:0]        num,
	input  logic [rmj_pkg::DEN_W-1:0]         den,
	input  logic                              sq,
	output logic [rmj_pkg::DATA_WIDTH-1:0]    k
);

	localparam int DW = rmj_pkg::DATA_WIDTH;
	localparam int QW = rmj_pkg::QUOT_W;
	localparam int NW = rmj_pkg::DEN_W;

	logic [QW-1:0] rem_s [DW-1];
	logic [QW-1:0] acc_s [DW-1];
	logic [NW-1:0] den_s [DW-1];
	logic          sq_s  [DW-1];
	logic [DW-1:0] quo_s [DW];

	for (genvar j = 0; j < DW; j++) begin : g_step
		localparam int SH = DW - 1 - j;
		logic [QW-1:0] rem_in;
		logic [QW-1:0] acc_in;
		logic [NW-1:0] den_in;
		logic          sq_in;
		logic [DW-1:0] quo_in;
		logic [QW-1:0] shifted;
		logic [QW-1:0] trial;
		logic          take;
		logic [DW-1:0] quo_nx;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign acc_in = '0;
			assign den_in = den;
			assign sq_in  = sq;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign acc_in = acc_s[j-1];
			assign den_in = den_s[j-1];
			assign sq_in  = sq_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		always_comb begin
			shifted = QW'(den_in) << SH;
			trial   = sq_in ? (((acc_in << 1) + shifted) << SH) : shifted;
			take    = trial <= rem_in;
			quo_nx  = quo_in;
			quo_nx[SH] = take;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j] <= quo_nx;
			end
		end

		if (j < DW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= take ? rem_in - trial : rem_in;
					acc_s[j] <= take ? acc_in + shifted : acc_in;
					den_s[j] <= den_in;
					sq_s[j]  <= sq_in;
				end
			end
		end
	end

	assign k = quo_s[DW-1];

endmodule
